// ===== sv/assert_macros.svh =====
// Assertion helpers used by the engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SIE_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SIE_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sie_pkg.sv =====
package sie_pkg;

   localparam int VAL_W = 31;

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_RUN    = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STS_ELEMENT = 3'd0,
      STS_ACCEPT  = 3'd1,
      STS_DUP     = 3'd2,
      STS_FULL    = 3'd3,
      STS_EMPTY   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_LOAD  = 3'd1,
      ST_ISECT = 3'd2,
      ST_UNA   = 3'd3,
      ST_UNB   = 3'd4,
      ST_FIN   = 3'd5
   } fsm_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             kind;
      status_type       status;
      logic             last;
   } rsp_item_type;

endpackage

// ===== sv/sie_req_if.sv =====
interface sie_req_if;
   import sie_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       op;
   logic [VAL_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink (input valid, input op, input value, output ready);
endinterface

// ===== sv/sie_rsp_if.sv =====
interface sie_rsp_if;
   import sie_pkg::*;

   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] value_out;
   logic             result_kind;
   logic [2:0]       status;
   logic             last_of_run;

   modport source (output valid, output value_out, output result_kind, output status,
                   output last_of_run, input ready);
   modport sink (input valid, input value_out, input result_kind, input status,
                 input last_of_run, output ready);
endinterface

// ===== sv/sie_set_mem.sv =====
module sie_set_mem #(
   parameter int SET_SIZE = 16,
   parameter int AW       = 4
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [AW-1:0]             waddr,
   input  logic [sie_pkg::VAL_W-1:0] wdata,
   input  logic [AW-1:0]             raddr,
   output logic [sie_pkg::VAL_W-1:0] rdata
);
   import sie_pkg::*;

   logic [VAL_W-1:0] mem_ff [SET_SIZE];
   logic [VAL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/sie_out_reg.sv =====
module sie_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_vld,
   input  sie_pkg::rsp_item_type push_item,
   output logic                  push_rdy,
   sie_rsp_if.source             rsp_ch
);
   import sie_pkg::*;

   logic         vld_ff, vld_in;
   rsp_item_type item_ff;

   assign push_rdy = !vld_ff || rsp_ch.ready;

   always_comb begin
      vld_in = vld_ff;
      if (push_rdy) begin
         vld_in = push_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_rdy && push_vld) begin
         item_ff <= push_item;
      end
   end

   assign rsp_ch.valid       = vld_ff;
   assign rsp_ch.value_out   = item_ff.value;
   assign rsp_ch.result_kind = item_ff.kind;
   assign rsp_ch.status      = item_ff.status;
   assign rsp_ch.last_of_run = item_ff.last;

endmodule

// ===== sv/sie_ctrl.sv =====
module sie_ctrl #(
   parameter int SET_SIZE = 16,
   parameter int AW       = 4,
   parameter int CW       = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_vld,
   input  sie_pkg::op_type           req_op,
   input  logic [sie_pkg::VAL_W-1:0] req_value,
   output logic                      req_rdy,
   input  logic [sie_pkg::VAL_W-1:0] rd_a,
   input  logic [sie_pkg::VAL_W-1:0] rd_b,
   output logic [AW-1:0]             raddr_a,
   output logic [AW-1:0]             raddr_b,
   output logic                      we_a,
   output logic                      we_b,
   output logic [AW-1:0]             waddr,
   output logic [sie_pkg::VAL_W-1:0] wdata,
   output logic                      push_vld,
   output sie_pkg::rsp_item_type     push_item,
   input  logic                      push_rdy,
   output logic [CW-1:0]             a_cnt,
   output logic [CW-1:0]             b_cnt
);
   import sie_pkg::*;

   fsm_type          st_ff, st_in;
   logic             ph_ff, ph_in;
   logic             sel_b_ff, sel_b_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [CW-1:0]    ia_ff, ia_in;
   logic [CW-1:0]    ib_ff, ib_in;
   logic [CW-1:0]    a_cnt_ff, a_cnt_in;
   logic [CW-1:0]    b_cnt_ff, b_cnt_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [VAL_W-1:0] pend_val_ff, pend_val_in;
   logic             pend_kind_ff, pend_kind_in;

   logic             emit_ok;
   logic             new_vld;
   logic [VAL_W-1:0] new_val;
   logic             new_kind;
   logic [CW-1:0]    own_cnt;
   logic [VAL_W-1:0] own_rd;

   assign emit_ok = !pend_vld_ff || push_rdy;
   assign own_cnt = sel_b_ff ? b_cnt_ff : a_cnt_ff;
   assign own_rd  = sel_b_ff ? rd_b : rd_a;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_vld) begin
               case (req_op)
                  OP_LOAD_A, OP_LOAD_B: st_in = ST_LOAD;
                  OP_RUN:               st_in = ST_ISECT;
                  default:              st_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            if (push_vld && push_rdy) begin
               st_in = ST_IDLE;
            end
         end
         ST_ISECT: begin
            if (!ph_ff && (ia_ff >= a_cnt_ff)) begin
               st_in = ST_UNA;
            end
         end
         ST_UNA: begin
            if (!ph_ff && (ia_ff >= a_cnt_ff)) begin
               st_in = ST_UNB;
            end
         end
         ST_UNB: begin
            if (!ph_ff && (ib_ff >= b_cnt_ff)) begin
               st_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (push_rdy) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ph_in        = ph_ff;
      sel_b_in     = sel_b_ff;
      val_in       = val_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      a_cnt_in     = a_cnt_ff;
      b_cnt_in     = b_cnt_ff;
      pend_vld_in  = pend_vld_ff;
      pend_val_in  = pend_val_ff;
      pend_kind_in = pend_kind_ff;
      req_rdy      = 1'b0;
      we_a         = 1'b0;
      we_b         = 1'b0;
      push_vld     = 1'b0;
      push_item    = '{value: '0, kind: 1'b0, status: STS_ELEMENT, last: 1'b1};
      new_vld      = 1'b0;
      new_val      = '0;
      new_kind     = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            req_rdy = 1'b1;
            if (req_vld) begin
               sel_b_in = (req_op == OP_LOAD_B);
               val_in   = req_value;
               ia_in    = '0;
               ib_in    = '0;
               ph_in    = 1'b0;
            end
         end
         ST_LOAD: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (ia_ff < own_cnt) begin
               if (own_rd == val_ff) begin
                  push_vld         = 1'b1;
                  push_item.status = STS_DUP;
               end else begin
                  ia_in = ia_ff + CW'(1);
                  ib_in = ib_ff + CW'(1);
                  ph_in = 1'b0;
               end
            end else if (own_cnt >= CW'(SET_SIZE)) begin
               push_vld         = 1'b1;
               push_item.status = STS_FULL;
            end else begin
               push_vld         = 1'b1;
               push_item.status = STS_ACCEPT;
               if (push_rdy) begin
                  we_a = !sel_b_ff;
                  we_b = sel_b_ff;
                  if (sel_b_ff) begin
                     b_cnt_in = b_cnt_ff + CW'(1);
                  end else begin
                     a_cnt_in = a_cnt_ff + CW'(1);
                  end
               end
            end
         end
         ST_ISECT: begin
            if (!ph_ff) begin
               if (ia_ff >= a_cnt_ff) begin
                  ia_in = '0;
                  ib_in = '0;
               end else begin
                  ph_in = 1'b1;
               end
            end else if (ib_ff < b_cnt_ff) begin
               if (rd_a == rd_b) begin
                  new_vld  = 1'b1;
                  new_val  = rd_a;
                  new_kind = 1'b0;
                  if (emit_ok) begin
                     ia_in = ia_ff + CW'(1);
                     ib_in = '0;
                     ph_in = 1'b0;
                  end
               end else begin
                  ib_in = ib_ff + CW'(1);
                  ph_in = 1'b0;
               end
            end else begin
               ia_in = ia_ff + CW'(1);
               ib_in = '0;
               ph_in = 1'b0;
            end
         end
         ST_UNA: begin
            if (!ph_ff) begin
               if (ia_ff >= a_cnt_ff) begin
                  ia_in = '0;
                  ib_in = '0;
               end else begin
                  ph_in = 1'b1;
               end
            end else begin
               new_vld  = 1'b1;
               new_val  = rd_a;
               new_kind = 1'b1;
               if (emit_ok) begin
                  ia_in = ia_ff + CW'(1);
                  ph_in = 1'b0;
               end
            end
         end
         ST_UNB: begin
            if (!ph_ff) begin
               if (ib_ff < b_cnt_ff) begin
                  ph_in = 1'b1;
               end
            end else if (ia_ff < a_cnt_ff) begin
               if (rd_a == rd_b) begin
                  ib_in = ib_ff + CW'(1);
                  ia_in = '0;
               end else begin
                  ia_in = ia_ff + CW'(1);
               end
               ph_in = 1'b0;
            end else begin
               new_vld  = 1'b1;
               new_val  = rd_b;
               new_kind = 1'b1;
               if (emit_ok) begin
                  ib_in = ib_ff + CW'(1);
                  ia_in = '0;
                  ph_in = 1'b0;
               end
            end
         end
         ST_FIN: begin
            push_vld = 1'b1;
            if (pend_vld_ff) begin
               push_item = '{value: pend_val_ff, kind: pend_kind_ff, status: STS_ELEMENT,
                             last: 1'b1};
            end else begin
               push_item.status = STS_EMPTY;
            end
            if (push_rdy) begin
               a_cnt_in    = '0;
               b_cnt_in    = '0;
               pend_vld_in = 1'b0;
            end
         end
         default: begin
            ph_in = 1'b0;
         end
      endcase

      // one-deep hold so the final element of a run can carry last
      if (new_vld) begin
         if (pend_vld_ff) begin
            push_vld  = 1'b1;
            push_item = '{value: pend_val_ff, kind: pend_kind_ff, status: STS_ELEMENT,
                          last: 1'b0};
         end
         if (emit_ok) begin
            pend_vld_in  = 1'b1;
            pend_val_in  = new_val;
            pend_kind_in = new_kind;
         end
      end
   end

   assign raddr_a = ia_ff[AW-1:0];
   assign raddr_b = ib_ff[AW-1:0];
   assign waddr   = own_cnt[AW-1:0];
   assign wdata   = val_ff;
   assign a_cnt   = a_cnt_ff;
   assign b_cnt   = b_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         ph_ff       <= 1'b0;
         a_cnt_ff    <= '0;
         b_cnt_ff    <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         st_ff       <= st_in;
         ph_ff       <= ph_in;
         a_cnt_ff    <= a_cnt_in;
         b_cnt_ff    <= b_cnt_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_b_ff     <= sel_b_in;
      val_ff       <= val_in;
      ia_ff        <= ia_in;
      ib_ff        <= ib_in;
      pend_val_ff  <= pend_val_in;
      pend_kind_ff <= pend_kind_in;
   end

endmodule

// ===== sv/set_intersection_union_engine.sv =====
// Set intersection / union engine.
// req_ch carries requests: op 0 loads value into set A, op 1 into set B,
// op 2 runs, op 3 is taken and ignored. rsp_ch returns results.
// A load answers with one status result (accepted, duplicate, full) that
// has last_of_run set. A run returns the intersection in A order, then all
// of A, then the B members not in A, and marks the final one with
// last_of_run; with both sets empty it returns a single empty status.
// A run leaves both sets empty.
// One request is worked on at a time; req_ch.ready is high only when idle.
// Each set lives in its own synchronous RAM (one read port, one write port),
// and every probe has an address phase followed by a compare phase.
// Results go through an output register; while the receiver stalls the
// engine holds its position and resumes with nothing lost.
// Synchronous reset empties both sets and drops any result in flight;
// no clearing pass is needed.
`include "assert_macros.svh"

module set_intersection_union_engine #(
   parameter int SET_SIZE = 16
) (
   input  logic      clock,
   input  logic      reset,
   sie_req_if.sink   req_ch,
   sie_rsp_if.source rsp_ch
);
   import sie_pkg::*;

   localparam int AW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
   localparam int CW = $clog2(SET_SIZE + 1);

   logic             req_rdy;
   logic [VAL_W-1:0] rd_a, rd_b;
   logic [AW-1:0]    raddr_a, raddr_b, waddr;
   logic             we_a, we_b;
   logic [VAL_W-1:0] wdata;
   logic             push_vld, push_rdy;
   rsp_item_type     push_item;
   logic [CW-1:0]    a_cnt, b_cnt;
   logic             cnt_ok, run_take, sts_push;

   assign req_ch.ready = req_rdy;

   sie_ctrl #(.SET_SIZE(SET_SIZE), .AW(AW), .CW(CW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_vld   (req_ch.valid),
      .req_op    (op_type'(req_ch.op)),
      .req_value (req_ch.value),
      .req_rdy   (req_rdy),
      .rd_a      (rd_a),
      .rd_b      (rd_b),
      .raddr_a   (raddr_a),
      .raddr_b   (raddr_b),
      .we_a      (we_a),
      .we_b      (we_b),
      .waddr     (waddr),
      .wdata     (wdata),
      .push_vld  (push_vld),
      .push_item (push_item),
      .push_rdy  (push_rdy),
      .a_cnt     (a_cnt),
      .b_cnt     (b_cnt)
   );

   sie_set_mem #(.SET_SIZE(SET_SIZE), .AW(AW)) u_mem_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr_a),
      .rdata (rd_a)
   );

   sie_set_mem #(.SET_SIZE(SET_SIZE), .AW(AW)) u_mem_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr_b),
      .rdata (rd_b)
   );

   sie_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .push_vld  (push_vld),
      .push_item (push_item),
      .push_rdy  (push_rdy),
      .rsp_ch    (rsp_ch)
   );

   assign cnt_ok   = (a_cnt <= CW'(SET_SIZE)) && (b_cnt <= CW'(SET_SIZE));
   assign run_take = req_ch.valid && req_ch.ready && (req_ch.op == OP_RUN);
   assign sts_push = push_vld && (push_item.status != STS_ELEMENT);

   `SIE_ASSERT_IMP(cnt_bound, clock, reset, 1'b1, cnt_ok, "set count exceeds capacity")
   `SIE_ASSERT_NXT(run_busy, clock, reset, run_take, !req_ch.ready, "request taken during run")
   `SIE_ASSERT_IMP(status_last, clock, reset, sts_push, push_item.last, "status without last")

endmodule
